FILE: hdl/ssre_pkg.sv
package ssre_pkg;

  localparam int unsigned CoordW  = 12;
  localparam int unsigned GainW   = 16;
  localparam int unsigned RadiusW = 16;
  localparam int unsigned GapW    = 21;
  localparam int unsigned FracW   = 16;
  localparam int unsigned SqW     = 2 * CoordW + 1;
  localparam int unsigned OpW     = 2 * GapW;
  localparam int unsigned RemW    = GapW + 4;

  typedef enum logic [1:0] {
    OP_SQRT = 2'b01,
    OP_DIV  = 2'b10
  } itr_op_e;

  typedef struct packed {
    logic    start;
    itr_op_e op;
  } itr_ctrl_t;

endpackage

FILE: hdl/ssre_mul.sv
module ssre_mul #(
  parameter int unsigned AW = 24,
  parameter int unsigned BW = 16
) (
  input  logic             clk_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  output logic [AW+BW-1:0] p_o
);

  logic [AW+BW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= (AW+BW)'(a_i) * (AW+BW)'(b_i);
  end

  assign p_o = p_q;

endmodule

FILE: hdl/ssre_itr.sv
module ssre_itr #(
  parameter int unsigned ResW = 24,
  parameter int unsigned DivW = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ssre_pkg::itr_ctrl_t     ctrl_i,
  input  logic [ssre_pkg::OpW-1:0] opnd_i,
  input  logic [DivW-1:0]         divisor_i,
  output logic                    done_o,
  output logic [ResW-1:0]         result_o
);

  localparam int unsigned OpW   = ssre_pkg::OpW;
  localparam int unsigned RemW  = ssre_pkg::RemW;
  localparam int unsigned GapW  = ssre_pkg::GapW;
  localparam int unsigned StepW = $clog2(ResW + 1);

  ssre_pkg::itr_op_e op_q;
  logic [OpW-1:0]    opnd_q, opnd_d;
  logic [DivW-1:0]   div_q;
  logic [RemW-1:0]   rem_q, rem_sh, trial, diff;
  logic [ResW-1:0]   res_q;
  logic [StepW-1:0]  step_q;
  logic              busy_q, done_q, ge;

  // one shift-compare-subtract step, root digit pair or quotient bit
  always_comb begin
    unique case (op_q)
      ssre_pkg::OP_SQRT: begin
        rem_sh = {rem_q[RemW-3:0], opnd_q[OpW-1 -: 2]};
        trial  = RemW'({res_q[GapW-1:0], 2'b01});
        opnd_d = {opnd_q[OpW-3:0], 2'b00};
      end
      ssre_pkg::OP_DIV: begin
        rem_sh = {rem_q[RemW-2:0], opnd_q[OpW-1]};
        trial  = RemW'(div_q);
        opnd_d = {opnd_q[OpW-2:0], 1'b0};
      end
      default: begin
        rem_sh = rem_q;
        trial  = '0;
        opnd_d = opnd_q;
      end
    endcase
    ge   = (rem_sh >= trial);
    diff = rem_sh - trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        step_q <= (ctrl_i.op == ssre_pkg::OP_SQRT) ? StepW'(GapW) : StepW'(ResW);
      end else if (busy_q) begin
        step_q <= step_q - StepW'(1);
        if (step_q == StepW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      op_q   <= ctrl_i.op;
      opnd_q <= opnd_i;
      div_q  <= divisor_i;
      rem_q  <= '0;
      res_q  <= '0;
    end else if (busy_q) begin
      opnd_q <= opnd_d;
      rem_q  <= ge ? diff : rem_sh;
      res_q  <= {res_q[ResW-2:0], ge};
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

FILE: hdl/stroke_speed_radius_estimator_top.sv
// stroke speed radius estimator
//
// in channel (in_valid_i/in_ready_o): one transaction per pointer event, action_i = 0 for
// begin or move with pos_x_i/pos_y_i, action_i = 1 for end of stroke
// out channel (out_valid_o/out_ready_i): one radius_o per begin or move, none for an end
// cfg channel (cfg_valid_i/cfg_ready_o): cfg_data_i writes radius_gain (Q8.8), always ready
//
// a move squares dx and dy on the shared multiplier, then runs 21 root steps and GW
// quotient steps on the shared shift-subtract unit, GW being the gap sum width (24 at
// depth 8), with sequencing states in between
// the first point of a stroke skips the squares and the root
// an end is taken in idle and leaves the estimator idle; in_ready_o is high only between items
//
// reset clears the history and the output valid flag and sets the gain to 1.0
// a result waits in the output register while the receiver stalls; the next item
// is taken meanwhile and its result is held until the register is free
module stroke_speed_radius_estimator_top #(
  parameter int unsigned HISTORY_DEPTH = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           action_i,
  input  logic [ssre_pkg::CoordW-1:0]    pos_x_i,
  input  logic [ssre_pkg::CoordW-1:0]    pos_y_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ssre_pkg::RadiusW-1:0]   radius_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ssre_pkg::GainW-1:0]     cfg_data_i
);

  localparam int unsigned RingN  = HISTORY_DEPTH - 1;
  localparam int unsigned PtrW   = (RingN > 1) ? $clog2(RingN) : 1;
  localparam int unsigned CntW   = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned GapW   = ssre_pkg::GapW;
  localparam int unsigned SumW   = GapW + $clog2(RingN);
  localparam int unsigned GainW  = ssre_pkg::GainW;
  localparam int unsigned CoordW = ssre_pkg::CoordW;
  localparam int unsigned SqW    = ssre_pkg::SqW;
  localparam int unsigned OpW    = ssre_pkg::OpW;
  localparam int unsigned FracW  = ssre_pkg::FracW;
  localparam int unsigned RadW   = ssre_pkg::RadiusW;
  localparam int unsigned ProdW  = SumW + GainW;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_SQ_X   = 9'b000000010,
    ST_SQ_Y   = 9'b000000100,
    ST_SQ_SUM = 9'b000001000,
    ST_ROOT   = 9'b000010000,
    ST_MUL_P  = 9'b000100000,
    ST_DIV_GO = 9'b001000000,
    ST_DIV_W  = 9'b010000000,
    ST_FIN    = 9'b100000000
  } state_e;

  state_e              state_q, state_d;
  logic [GainW-1:0]    gain_q;
  logic [CoordW-1:0]   last_x_q, last_y_q, x_q, y_q;
  logic [CoordW-1:0]   dx_q, dy_q;
  logic [SumW-1:0]     sum_q;
  logic [CntW-1:0]     cnt_q;
  logic [PtrW-1:0]     ptr_q;
  logic [GapW-1:0]     ring [RingN];
  logic [GapW-1:0]     rd_q;
  logic [SqW-1:0]      sq_q, sq_sum;
  logic [RadW-1:0]     res_q, radius_q, sat;
  logic                out_valid_q;

  logic                in_acc, ring_wr, full;
  logic [GapW-1:0]     gap;
  logic [SumW-1:0]     mul_a;
  logic [GainW-1:0]    mul_b;
  logic [ProdW-1:0]    prod;
  ssre_pkg::itr_ctrl_t itr_ctrl;
  logic [OpW-1:0]      itr_opnd;
  logic                itr_done;
  logic [SumW-1:0]     itr_res;

  assign in_acc      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign full        = (cnt_q == CntW'(HISTORY_DEPTH));
  assign gap         = itr_res[GapW-1:0];
  assign ring_wr     = (state_q == ST_ROOT) && itr_done;
  assign sq_sum      = sq_q + SqW'(prod);
  assign sat         = (|itr_res[SumW-1:RadW]) ? '1 : itr_res[RadW-1:0];

  // shared multiplier and shift-subtract unit operands
  always_comb begin
    mul_a          = sum_q;
    mul_b          = gain_q;
    itr_ctrl.start = 1'b0;
    itr_ctrl.op    = ssre_pkg::OP_SQRT;
    itr_opnd       = OpW'({sq_sum, {FracW{1'b0}}});
    unique case (state_q)
      ST_SQ_X: begin
        mul_a = SumW'(dx_q);
        mul_b = GainW'(dx_q);
      end
      ST_SQ_Y: begin
        mul_a = SumW'(dy_q);
        mul_b = GainW'(dy_q);
      end
      ST_SQ_SUM: begin
        itr_ctrl.start = 1'b1;
      end
      ST_DIV_GO: begin
        itr_ctrl.start = 1'b1;
        itr_ctrl.op    = ssre_pkg::OP_DIV;
        itr_opnd       = {prod[FracW +: SumW], {(OpW-SumW){1'b0}}};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && !action_i) begin
          state_d = (cnt_q == '0) ? ST_MUL_P : ST_SQ_X;
        end
      end
      ST_SQ_X:   state_d = ST_SQ_Y;
      ST_SQ_Y:   state_d = ST_SQ_SUM;
      ST_SQ_SUM: state_d = ST_ROOT;
      ST_ROOT: begin
        if (itr_done) begin
          state_d = ST_MUL_P;
        end
      end
      ST_MUL_P:  state_d = ST_DIV_GO;
      ST_DIV_GO: state_d = ST_DIV_W;
      ST_DIV_W: begin
        if (itr_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      gain_q      <= GainW'(256);
      last_x_q    <= '0;
      last_y_q    <= '0;
      sum_q       <= '0;
      cnt_q       <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        gain_q <= cfg_data_i;
      end
      if (in_acc) begin
        if (action_i) begin
          cnt_q <= '0;
          sum_q <= '0;
          ptr_q <= '0;
        end else if (cnt_q == '0) begin
          cnt_q    <= CntW'(1);
          last_x_q <= pos_x_i;
          last_y_q <= pos_y_i;
        end
      end
      if (ring_wr) begin
        if (full) begin
          sum_q <= sum_q - SumW'(rd_q) + SumW'(gap);
        end else begin
          sum_q <= sum_q + SumW'(gap);
          cnt_q <= cnt_q + CntW'(1);
        end
        ptr_q    <= (ptr_q == PtrW'(RingN - 1)) ? '0 : ptr_q + PtrW'(1);
        last_x_q <= x_q;
        last_y_q <= y_q;
      end
      if (state_q == ST_FIN && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q  <= pos_x_i;
      y_q  <= pos_y_i;
      dx_q <= (pos_x_i > last_x_q) ? pos_x_i - last_x_q : last_x_q - pos_x_i;
      dy_q <= (pos_y_i > last_y_q) ? pos_y_i - last_y_q : last_y_q - pos_y_i;
    end
    if (state_q == ST_SQ_Y) begin
      sq_q <= SqW'(prod);
    end
    if (state_q == ST_DIV_W && itr_done) begin
      res_q <= sat;
    end
    if (state_q == ST_FIN && (!out_valid_q || out_ready_i)) begin
      radius_q <= res_q;
    end
  end

  // gap ring, oldest entry read ahead of the write to the same slot
  always_ff @(posedge clk_i) begin
    if (ring_wr) begin
      ring[ptr_q] <= gap;
    end
    rd_q <= ring[ptr_q];
  end

  ssre_mul #(
    .AW (SumW),
    .BW (GainW)
  ) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  ssre_itr #(
    .ResW (SumW),
    .DivW (CntW)
  ) u_itr (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (itr_ctrl),
    .opnd_i    (itr_opnd),
    .divisor_i (cnt_q),
    .done_o    (itr_done),
    .result_o  (itr_res)
  );

  assign out_valid_o = out_valid_q;
  assign radius_o    = radius_q;

endmodule
